>>> src/mcfb_pkg.sv
package mcfb_pkg;

   // Frame geometry
   localparam int MOTORS      = 3;
   localparam int MAX_MOTORS  = 4;
   localparam int BODY_LEN    = MOTORS + 3;   // robot id, magnitudes, flags, sum
   localparam int FRAME_LEN   = MOTORS + 7;
   localparam int EMIT_IDX_W  = $clog2(FRAME_LEN);
   localparam int DIV_IDX_W   = $clog2(BODY_LEN + 1);

   // Configuration port
   localparam int MOD_W       = 17;
   localparam int CHECK_W     = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_MODULUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE    = 2'd2;

   localparam logic [MOD_W-1:0] CRC_MODULUS_RESET = 17'd4129;
   localparam logic [7:0]       START_BYTE_RESET  = 8'd27;
   localparam logic [7:0]       END_BYTE_RESET    = 8'd9;

   // Dribble modes and their flag bits
   localparam logic [1:0] DRIB_MODE_ONE = 2'd1;
   localparam logic [1:0] DRIB_MODE_TWO = 2'd2;
   localparam logic [7:0] DRIB_ONE_BITS = 8'b1000_0000;
   localparam logic [7:0] DRIB_TWO_BITS = 8'b1100_0000;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0] octet_type;

   typedef struct packed {
      logic [MOD_W-1:0] crc_modulus;
      octet_type        start_byte;
      octet_type        end_byte;
   } csr_type;

   // Body bytes in transmit order: index 0 is the robot id
   typedef struct packed {
      octet_type [BODY_LEN-1:0] bytes;
   } frame_body_type;

   typedef struct packed {
      logic           valid;
      frame_body_type body;
   } queue_head_type;

endpackage

>>> src/motor_command_frame_builder.sv
// The start byte of a frame passes through the request queue, the sequencer and the output register on its way to rsp.
// Throughput: one frame of FRAME_LEN (10) bytes at one byte per cycle while rsp_stall is low,
// set by the single-byte output register; the remainder unit folds one byte per
// cycle and finishes all BODY_LEN (6) body bytes under the emission of the frame.
// Reset: synchronous, active high; clears queue and sequencer, loads register defaults.
module motor_command_frame_builder
   import mcfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_robot_id,
   input  logic signed [8:0]      req_force_0,
   input  logic signed [8:0]      req_force_1,
   input  logic signed [8:0]      req_force_2,
   input  logic signed [8:0]      req_force_3,
   input  logic [1:0]             req_dribble_mode,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,

   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type        csr_ff;
   frame_body_type front_body;
   queue_head_type head;
   logic           queue_full;
   logic           push;
   logic           pop;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.crc_modulus <= CRC_MODULUS_RESET;
         csr_ff.start_byte  <= START_BYTE_RESET;
         csr_ff.end_byte    <= END_BYTE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CRC_MODULUS: csr_ff.crc_modulus <= csr_wdata[MOD_W-1:0];
            CSR_START_BYTE:  csr_ff.start_byte  <= csr_wdata[7:0];
            CSR_END_BYTE:    csr_ff.end_byte    <= csr_wdata[7:0];
            default:         csr_ff             <= csr_ff;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   mcfb_front u_front (
      .robot_id     (req_robot_id),
      .force_0      (req_force_0),
      .force_1      (req_force_1),
      .force_2      (req_force_2),
      .force_3      (req_force_3),
      .dribble_mode (req_dribble_mode),
      .body         (front_body)
   );

   mcfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_body (front_body),
      .full      (queue_full),
      .head      (head),
      .pop       (pop)
   );

   mcfb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .csr          (csr_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

>>> src/mcfb_front.sv
module mcfb_front
   import mcfb_pkg::*;
(
   input  logic [7:0]        robot_id,
   input  logic signed [8:0] force_0,
   input  logic signed [8:0] force_1,
   input  logic signed [8:0] force_2,
   input  logic signed [8:0] force_3,
   input  logic [1:0]        dribble_mode,
   output frame_body_type    body
);

   logic [MAX_MOTORS-1:0][8:0] forces;
   octet_type                  flags;
   octet_type                  sum;

   assign forces = {force_3, force_2, force_1, force_0};

   // Classify the request: magnitudes, sign and dribble flags, byte sum
   always_comb begin
      body = '0;
      unique case (dribble_mode)
         DRIB_MODE_ONE: flags = DRIB_ONE_BITS;
         DRIB_MODE_TWO: flags = DRIB_TWO_BITS;
         default:       flags = '0;
      endcase

      body.bytes[0] = robot_id;
      for (int m = 0; m < MOTORS; m++) begin
         if (forces[m][8]) begin
            body.bytes[1 + m] = 8'(~forces[m][7:0] + 8'd1);
            flags[m]          = 1'b1;
         end else begin
            body.bytes[1 + m] = forces[m][7:0];
         end
      end
      body.bytes[MOTORS + 1] = flags;

      // Sum robot id through flags, modulo 256
      sum = '0;
      for (int k = 0; k < MOTORS + 2; k++) begin
         sum = 8'(sum + body.bytes[k]);
      end
      body.bytes[MOTORS + 2] = sum;
   end

endmodule

>>> src/mcfb_queue.sv
module mcfb_queue
   import mcfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_body_type push_body,
   output logic           full,
   output queue_head_type head,
   input  logic           pop
);

   frame_body_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.body  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request body
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_body;
      end
   end

endmodule

>>> src/mcfb_back.sv
module mcfb_back
   import mcfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  csr_type        csr,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output octet_type      rsp_out_byte,
   output logic           rsp_last
);

   localparam logic [EMIT_IDX_W-1:0] SLOT_START    = '0;
   localparam logic [EMIT_IDX_W-1:0] SLOT_BODY_END = EMIT_IDX_W'(BODY_LEN);
   localparam logic [EMIT_IDX_W-1:0] SLOT_CHECK_HI = EMIT_IDX_W'(BODY_LEN + 1);
   localparam logic [EMIT_IDX_W-1:0] SLOT_CHECK_LO = EMIT_IDX_W'(BODY_LEN + 2);
   localparam logic [EMIT_IDX_W-1:0] SLOT_END      = EMIT_IDX_W'(FRAME_LEN - 1);

   logic                  busy_ff,     busy_in;
   frame_body_type        body_ff;
   logic [EMIT_IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic [DIV_IDX_W-1:0]  div_idx_ff,  div_idx_in;
   logic [MOD_W-1:0]      rem_ff,      rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   octet_type             rsp_byte_ff,  rsp_byte_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic      out_free;
   logic      div_done;
   logic      load;
   logic      load_last;
   octet_type div_byte;
   octet_type body_byte;

   // Fold one byte into the remainder, one compare and subtract per bit; a zero modulus just shifts the byte in
   function automatic logic [MOD_W-1:0] fold_byte(input logic [MOD_W-1:0] rem,
                                                  input octet_type        din,
                                                  input logic [MOD_W-1:0] modulus);
      logic [MOD_W:0]   t;
      logic [MOD_W-1:0] r;
      r = rem;
      if (modulus == '0) begin
         r = MOD_W'({r[7:0], din});
      end else begin
         for (int i = 7; i >= 0; i--) begin
            t = {r, din[i]};
            if (t >= {1'b0, modulus}) begin
               t = t - {1'b0, modulus};
            end
            r = t[MOD_W-1:0];
         end
      end
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_done  = (div_idx_ff == DIV_IDX_W'(BODY_LEN));
   assign load      = busy_ff && out_free && ((emit_idx_ff <= SLOT_BODY_END) || div_done);
   assign load_last = load && (emit_idx_ff == SLOT_END);
   assign pop       = head.valid && (!busy_ff || load_last);

   // Pick body bytes for the divider and the emitter
   always_comb begin
      div_byte  = '0;
      body_byte = '0;
      for (int k = 0; k < BODY_LEN; k++) begin
         if (div_idx_ff == DIV_IDX_W'(k)) begin
            div_byte = body_ff.bytes[k];
         end
         if (emit_idx_ff == EMIT_IDX_W'(k + 1)) begin
            body_byte = body_ff.bytes[k];
         end
      end
   end

   // Select the next frame byte
   always_comb begin
      priority if (emit_idx_ff == SLOT_START) begin
         rsp_byte_in = csr.start_byte;
      end else if (emit_idx_ff <= SLOT_BODY_END) begin
         rsp_byte_in = body_byte;
      end else if (emit_idx_ff == SLOT_CHECK_HI) begin
         rsp_byte_in = rem_ff[CHECK_W-1:8];
      end else if (emit_idx_ff == SLOT_CHECK_LO) begin
         rsp_byte_in = rem_ff[7:0];
      end else begin
         rsp_byte_in = csr.end_byte;
      end
      rsp_last_in = (emit_idx_ff == SLOT_END);
   end

   // Sequence the frame: take a body, run the remainder, emit bytes
   always_comb begin
      busy_in      = busy_ff;
      emit_idx_in  = emit_idx_ff;
      div_idx_in   = div_idx_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         emit_idx_in  = EMIT_IDX_W'(emit_idx_ff + 1'b1);
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (busy_ff && !div_done) begin
         rem_in     = fold_byte(rem_ff, div_byte, csr.crc_modulus);
         div_idx_in = DIV_IDX_W'(div_idx_ff + 1'b1);
      end

      if (load_last) begin
         busy_in = 1'b0;
      end

      if (pop) begin
         busy_in     = 1'b1;
         emit_idx_in = '0;
         div_idx_in  = '0;
         rem_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         emit_idx_ff  <= '0;
         div_idx_ff   <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         emit_idx_ff  <= emit_idx_in;
         div_idx_ff   <= div_idx_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         body_ff <= head.body;
      end
      if (load) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> src/mcfb_checker.sv
module mcfb_checker
   import mcfb_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   localparam int CNT_W = $clog2(FRAME_LEN);

   logic             req_take;
   logic             rsp_take;
   logic [2:0]       pending_ff, pending_in;
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Track frames in flight and byte position within the frame
   always_comb begin
      pending_in  = 3'(pending_ff + {2'b00, req_take} - {2'b00, rsp_take && rsp_last});
      byte_cnt_in = byte_cnt_ff;
      if (rsp_take) begin
         byte_cnt_in = rsp_last ? '0 : CNT_W'(byte_cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         byte_cnt_ff <= '0;
      end else begin
         pending_ff  <= pending_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response byte without a pending request");

   a_last_place: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_last == (byte_cnt_ff == CNT_W'(FRAME_LEN - 1)))
      else $error("last flag not on the final frame byte");

endmodule

bind motor_command_frame_builder mcfb_checker u_mcfb_checker (.*);

>>> bench/motor_command_frame_builder_tb.sv
module motor_command_frame_builder_tb;
   import mcfb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 20;

   // Index with no register behind it; writes there must leave the frame alone
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      octet_type                   robot_id;
      logic [MAX_MOTORS-1:0][8:0]  drive;
      logic [1:0]                  dribble_mode;
   } motor_cmd_type;

   typedef struct {
      octet_type value;
      logic      last;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset;

   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_robot_id;
   logic signed [8:0]      req_force_0;
   logic signed [8:0]      req_force_1;
   logic signed [8:0]      req_force_2;
   logic signed [8:0]      req_force_3;
   logic [1:0]             req_dribble_mode;

   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_last;

   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Register copy used for framing
   logic [MOD_W-1:0] modulus_cfg;
   octet_type        start_cfg;
   octet_type        end_cfg;

   frame_byte_type frame_bytes_due[$];

   int  error_count   = 0;
   int  command_count = 0;
   int  byte_count    = 0;
   int  frame_count   = 0;
   int  setting_count = 0;
   int  byte_pos      = 0;
   int  idle_cycles   = 0;
   bit  req_idle_on   = 1'b0;
   bit  rsp_idle_on   = 1'b0;
   bit  rsp_hold_due  = 1'b0;

   motor_command_frame_builder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_robot_id     (req_robot_id),
      .req_force_0      (req_force_0),
      .req_force_1      (req_force_1),
      .req_force_2      (req_force_2),
      .req_force_3      (req_force_3),
      .req_dribble_mode (req_dribble_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build the full frame for one request and queue its bytes in transmit order
   function automatic void build_frame(input motor_cmd_type cmd);
      octet_type  body [BODY_LEN];
      octet_type  flags;
      octet_type  sum;
      logic [9:0] magnitude;
      logic [63:0] word;
      logic [15:0] check;
      int m;
      flags   = '0;
      body[0] = cmd.robot_id;
      for (m = 0; m < MOTORS; m++) begin
         if (cmd.drive[m][8]) begin
            // minus 256 wraps to a zero byte, sign flag still set
            magnitude   = 10'h200 - {1'b0, cmd.drive[m]};
            body[1 + m] = magnitude[7:0];
            flags[m]    = 1'b1;
         end else begin
            body[1 + m] = cmd.drive[m][7:0];
         end
      end
      if (cmd.dribble_mode == DRIB_MODE_ONE) begin
         flags = flags | DRIB_ONE_BITS;
      end else if (cmd.dribble_mode == DRIB_MODE_TWO) begin
         flags = flags | DRIB_TWO_BITS;
      end
      body[MOTORS + 1] = flags;
      sum = '0;
      for (m = 0; m <= MOTORS + 1; m++) sum = sum + body[m];
      body[MOTORS + 2] = sum;
      // Check word: big-endian body as one number, reduced by the modulus
      word = '0;
      for (m = 0; m < BODY_LEN; m++) word = {word[55:0], body[m]};
      if (modulus_cfg != '0) word = word % {47'd0, modulus_cfg};
      check = word[15:0];
      frame_bytes_due.push_back('{start_cfg, 1'b0});
      for (m = 0; m < BODY_LEN; m++) frame_bytes_due.push_back('{body[m], 1'b0});
      frame_bytes_due.push_back('{check[15:8], 1'b0});
      frame_bytes_due.push_back('{check[7:0], 1'b0});
      frame_bytes_due.push_back('{end_cfg, 1'b1});
   endfunction

   function automatic motor_cmd_type make_command(input octet_type id,
                                                  input logic [8:0] d0, input logic [8:0] d1,
                                                  input logic [8:0] d2, input logic [8:0] d3,
                                                  input logic [1:0] mode);
      motor_cmd_type cmd;
      cmd.robot_id     = id;
      cmd.drive        = {d3, d2, d1, d0};
      cmd.dribble_mode = mode;
      return cmd;
   endfunction

   function automatic motor_cmd_type random_command();
      motor_cmd_type cmd;
      int m;
      cmd.robot_id = 8'($urandom_range(0, 255));
      for (m = 0; m < MAX_MOTORS; m++) begin
         case ($urandom_range(0, 7))
            0:       cmd.drive[m] = 9'h100;
            1:       cmd.drive[m] = 9'h101;
            2:       cmd.drive[m] = 9'h0FF;
            default: cmd.drive[m] = 9'($urandom_range(0, 511));
         endcase
      end
      cmd.dribble_mode = 2'($urandom_range(0, 3));
      return cmd;
   endfunction

   function automatic logic [MOD_W-1:0] random_modulus();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 17'd1;
         2:       return 17'($urandom_range(65537, 131071));
         3:       return 17'd65536;
         4:       return 17'd2;
         default: return 17'($urandom_range(2, 65535));
      endcase
   endfunction

   // Offer one request, with an optional idle burst ahead of it
   task automatic send_command(input motor_cmd_type cmd);
      int gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_robot_id     <= cmd.robot_id;
      req_force_0      <= cmd.drive[0];
      req_force_1      <= cmd.drive[1];
      req_force_2      <= cmd.drive[2];
      req_force_3      <= cmd.drive[3];
      req_dribble_mode <= cmd.dribble_mode;
      do @(posedge clock); while (req_stall);
      build_frame(cmd);
      command_count++;
   endtask

   // Drop valid and hold until every queued frame byte has come back
   task automatic wait_frames_drained();
      req_valid <= 1'b0;
      wait (frame_bytes_due.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CRC_MODULUS: modulus_cfg = data;
         CSR_START_BYTE:  start_cfg   = data[7:0];
         CSR_END_BYTE:    end_cfg     = data[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [MOD_W-1:0] modulus,
                                input logic [CSR_DATA_W-1:0] start_data,
                                input logic [CSR_DATA_W-1:0] end_data);
      wait_frames_drained();
      write_register(CSR_CRC_MODULUS, modulus);
      write_register(CSR_START_BYTE, start_data);
      write_register(CSR_END_BYTE, end_data);
      setting_count++;
   endtask

   // Extremes of every field under the reset register values
   task automatic test_field_extremes();
      send_command(make_command(8'd0, 9'd0, 9'd0, 9'd0, 9'd0, 2'd0));
      send_command(make_command(8'd255, 9'd255, 9'd255, 9'd255, 9'd255, DRIB_MODE_ONE));
      send_command(make_command(8'd1, -9'sd255, -9'sd255, -9'sd255, 9'd0, DRIB_MODE_TWO));
      // minus 256 on motors 0, 2 and 3
      send_command(make_command(8'd128, 9'h100, 9'd1, 9'h100, 9'h100, 2'd0));
      send_command(make_command(8'd77, 9'd1, 9'h100, -9'sd1, 9'h0AA, DRIB_MODE_ONE));
      // dribble mode three leaves the dribble bits clear
      send_command(make_command(8'd200, -9'sd3, 9'd100, 9'h100, 9'h155, 2'd3));
      send_command(make_command(8'd15, 9'd0, 9'd0, 9'd0, 9'h1FF, 2'd3));
      // unused motor field must not leak into the frame
      send_command(make_command(8'd15, 9'd0, 9'd0, 9'd0, 9'h100, 2'd3));
      send_command(make_command(8'h55, 9'h0AA, 9'h155, 9'h055, 9'h0FF, DRIB_MODE_TWO));
      send_command(make_command(8'hAA, 9'h155, 9'h0AA, 9'h1AA, 9'h000, 2'd0));
   endtask

   // Register extremes, modulus zero and above 16 bits included
   task automatic test_register_extremes();
      int k;
      apply_setting(17'd2, 17'd0, 17'd255);
      for (k = 0; k < 5; k++) send_command(random_command());
      apply_setting(17'd65536, 17'd255, 17'd0);
      for (k = 0; k < 5; k++) send_command(random_command());
      apply_setting(17'd0, 17'h1FF5A, 17'h100A5);
      for (k = 0; k < 5; k++) send_command(random_command());
      apply_setting(17'd1, 17'h0AA, 17'h055);
      for (k = 0; k < 5; k++) send_command(random_command());
      apply_setting(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      for (k = 0; k < 5; k++) send_command(random_command());
      apply_setting(17'd65537, 17'd27, 17'd9);
      for (k = 0; k < 5; k++) send_command(random_command());
      // write to the unmapped index, frames keep the current settings
      wait_frames_drained();
      write_register(CSR_UNMAPPED, 17'h1FFFF);
      apply_setting(17'd65535, 17'd0, 17'd0);
      for (k = 0; k < 5; k++) send_command(random_command());
   endtask

   // Long receiver hold while requests keep coming, then a full drain
   task automatic test_output_backpressure();
      int k;
      rsp_idle_on  = 1'b0;
      req_idle_on  = 1'b0;
      rsp_hold_due = 1'b1;
      for (k = 0; k < 12; k++) send_command(random_command());
      wait_frames_drained();
   endtask

   task automatic test_random_traffic(input int n_items, input bit with_idling);
      int k;
      req_idle_on = with_idling;
      rsp_idle_on = with_idling;
      for (k = 0; k < n_items; k++) begin
         if (k != 0 && k % 40 == 0) begin
            apply_setting(random_modulus(), 17'($urandom_range(0, 131071)),
                          17'($urandom_range(0, 131071)));
         end
         send_command(random_command());
      end
   endtask

   // Receiver: long hold on request, random stall bursts otherwise
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_due) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall    <= 1'b0;
            rsp_hold_due = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted frame byte with the oldest one due
   always @(posedge clock) begin : check_frame_bytes
      frame_byte_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         byte_count++;
         if (frame_bytes_due.size() == 0) begin
            $display("%0t: unexpected byte, expected none, got %02h last %0b",
                     $time, rsp_out_byte, rsp_last);
            error_count++;
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_out_byte !== due.value) begin
               $display("%0t: frame %0d byte %0d: expected out_byte %02h, got %02h",
                        $time, frame_count, byte_pos, due.value, rsp_out_byte);
               error_count++;
            end
            if (rsp_last !== due.last) begin
               $display("%0t: frame %0d byte %0d: expected last %0b, got %0b",
                        $time, frame_count, byte_pos, due.last, rsp_last);
               error_count++;
            end
            byte_pos++;
            if (due.last) begin
               byte_pos = 0;
               frame_count++;
            end
         end
      end
   end

   // Abort when no handshake happens on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d bytes still due",
                     $time, idle_cycles, frame_bytes_due.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_robot_id     = '0;
      req_force_0      = '0;
      req_force_1      = '0;
      req_force_2      = '0;
      req_force_3      = '0;
      req_dribble_mode = '0;
      csr_write        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      modulus_cfg      = CRC_MODULUS_RESET;
      start_cfg        = START_BYTE_RESET;
      end_cfg          = END_BYTE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic(360, 1'b1);
      // closing stretch without idling on either side
      test_random_traffic(60, 1'b0);

      wait_frames_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d commands, %0d frames, %0d frame bytes checked",
               command_count, frame_count, byte_count);
      $display("across %0d register settings, a long output hold and random idle bursts",
               setting_count);
      if (error_count == 0 && frame_bytes_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/mcfb_pkg.sv
src/mcfb_front.sv
src/mcfb_queue.sv
src/mcfb_back.sv
src/motor_command_frame_builder.sv
src/mcfb_checker.sv
bench/motor_command_frame_builder_tb.sv
